[rtl/core/arbsc_pkg.sv]
package arbsc_pkg;

	localparam int REQ_W      = 3;
	localparam int SAMPLE_W   = 16;
	localparam int STATUS_W   = 2;
	localparam int FILL_OUT_W = 12;
	localparam int POS_W      = 41;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;
	localparam int RATE_W     = 18;
	localparam int BASE_W     = 40;
	localparam int PLAYED_W   = 48;
	// (played/2)*1000 stays below 2^57.
	localparam int DIVIDEND_W = 57;

	localparam logic [16:0] KNEE       = 17'd13107;
	localparam int          CLIP_SHIFT = 5;
	localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;
	localparam logic [63:0] ONE_Q38    = 64'd1 << 38;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQUEUE   = 3'd0,
		REQ_PULL      = 3'd1,
		REQ_FLUSH     = 3'd2,
		REQ_CLEAR     = 3'd3,
		REQ_RESET_ALL = 3'd4
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_UNDERRUN = 2'd2,
		ST_STOPPED  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RUNNING     = 2'd0,
		CFG_SAMPLE_RATE = 2'd1,
		CFG_POS_BASE    = 2'd2
	} cfg_idx_t;

	// High 64 bits of a 64 x 64 product; used only while the clip table is built.
	function automatic logic [63:0] mul_high(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] m;
		logic [63:0] p00, p01, p10, p11, mid;
		m   = 64'h0000_0000_FFFF_FFFF;
		p00 = (a & m) * (b & m);
		p01 = (a & m) * (b >> 32);
		p10 = (a >> 32) * (b & m);
		p11 = (a >> 32) * (b >> 32);
		mid = (p00 >> 32) + (p01 & m) + (p10 & m);
		return p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
	endfunction

	// Unsigned 64-bit quotient by long division; only evaluated while tables are built.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(1/256) - 1 as a Q64 fraction, by its Taylor series.
	function automatic logic [63:0] exp_step();
		logic [63:0] term, step;
		term = 64'd1 << 56;
		step = term;
		for (int n = 2; n <= 12; n++) begin
			term = udiv64(term >> 8, 64'(n));
			step = step + term;
		end
		return step;
	endfunction

endpackage

[rtl/core/arbsc_if.sv]
interface arbsc_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [arbsc_pkg::REQ_W-1:0]            req_type;
	logic signed [arbsc_pkg::SAMPLE_W-1:0]  sample_in;

	modport source (output valid, req_type, sample_in, input ready);
	modport sink   (input valid, req_type, sample_in, output ready);
endinterface

interface arbsc_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [arbsc_pkg::SAMPLE_W-1:0]  sample_out;
	logic [arbsc_pkg::STATUS_W-1:0]         status;
	logic [arbsc_pkg::FILL_OUT_W-1:0]       fill_level;
	logic [arbsc_pkg::POS_W-1:0]            position_ms;

	modport source (output valid, sample_out, status, fill_level, position_ms, input ready);
	modport sink   (input valid, sample_out, status, fill_level, position_ms, output ready);
endinterface

interface arbsc_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [arbsc_pkg::CFG_IDX_W-1:0]        index;
	logic [arbsc_pkg::CFG_DATA_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/audio_ring_buffer_soft_clip_unit.sv]
// Channel  Modport  Moves                Fields
// req      sink     one request          req_type, sample_in
// rsp      source   one result           sample_out, status, fill_level, position_ms
// cfg      sink     one register write   index, data (always ready)
//
// A request goes through states READ, DIV and OUT to its result in the output
// register; DIV runs the one-bit-per-cycle restoring divider for position_ms.
// Requests are worked one at a time; the next is accepted while a result waits.
// The sample store is a one-port-read, one-port-write memory with registered read.
// Reset clears pointers, played count, running, base; rate is 44100; store is kept.
// A stalled result holds the output register, and the next result waits behind it.
module audio_ring_buffer_soft_clip_unit #(
	parameter int FIFO_DEPTH       = 4096,
	parameter int CLIP_ROM_ENTRIES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	arbsc_req_if.sink     req,
	arbsc_rsp_if.source   rsp,
	arbsc_cfg_if.sink     cfg
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FILL_W = PTR_W + 1;
	localparam int EXT_W = (FILL_W > arbsc_pkg::FILL_OUT_W) ? FILL_W : arbsc_pkg::FILL_OUT_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t                               state_q;
	logic [PTR_W-1:0]                     rd_ptr_q;
	logic [PTR_W-1:0]                     wr_ptr_q;
	logic [arbsc_pkg::PLAYED_W-1:0]       played_q;
	logic                                 running_q;
	logic [arbsc_pkg::RATE_W-1:0]         rate_q;
	logic [arbsc_pkg::BASE_W-1:0]         base_q;
	logic                                 pull_ok_q;
	logic                                 out_valid_q;

	arbsc_pkg::status_t                   status_q;
	logic [arbsc_pkg::SAMPLE_W-1:0]       sample_q;
	logic signed [arbsc_pkg::SAMPLE_W-1:0] out_sample_q;
	logic [arbsc_pkg::STATUS_W-1:0]       out_status_q;
	logic [arbsc_pkg::FILL_OUT_W-1:0]     out_fill_q;
	logic [arbsc_pkg::POS_W-1:0]          out_pos_q;

	logic                                 accept;
	arbsc_pkg::req_t                      req_code;
	logic [PTR_W-1:0]                     wr_next;
	logic [PTR_W-1:0]                     rd_next;
	logic                                 full;
	logic                                 empty;
	logic                                 mem_we;
	logic                                 mem_re;
	arbsc_pkg::status_t                   req_status;
	logic [FILL_W-1:0]                    fill_cnt;
	logic [EXT_W-1:0]                     fill_ext;
	logic                                 load_out;
	logic [arbsc_pkg::SAMPLE_W-1:0]       rd_data;
	logic [arbsc_pkg::SAMPLE_W-1:0]       clip_out;
	logic                                 div_done;
	logic [arbsc_pkg::POS_W-1:0]          div_pos;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;
	assign req_code  = arbsc_pkg::req_t'(req.req_type);

	always_comb begin
		wr_next = (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
		rd_next = (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		full    = (wr_next == rd_ptr_q);
		empty   = (rd_ptr_q == wr_ptr_q);
		mem_we  = accept && (req_code == arbsc_pkg::REQ_ENQUEUE) && running_q && !full;
		mem_re  = accept && (req_code == arbsc_pkg::REQ_PULL) && running_q && !empty;

		req_status = arbsc_pkg::ST_OK;
		if (req_code == arbsc_pkg::REQ_ENQUEUE || req_code == arbsc_pkg::REQ_PULL) begin
			if (!running_q) begin
				req_status = arbsc_pkg::ST_STOPPED;
			end else if (req_code == arbsc_pkg::REQ_ENQUEUE && full) begin
				req_status = arbsc_pkg::ST_FULL;
			end else if (req_code == arbsc_pkg::REQ_PULL && empty) begin
				req_status = arbsc_pkg::ST_UNDERRUN;
			end
		end

		fill_cnt = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q}
			+ ((wr_ptr_q < rd_ptr_q) ? FILL_W'(FIFO_DEPTH) : FILL_W'(0));
		fill_ext = EXT_W'(fill_cnt);
		load_out = (state_q == S_OUT) && (!out_valid_q || rsp.ready);
	end

	arbsc_ram #(
		.DEPTH (FIFO_DEPTH),
		.AW    (PTR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_ptr_q),
		.wdata (req.sample_in),
		.re    (mem_re),
		.raddr (rd_ptr_q),
		.rdata (rd_data)
	);

	arbsc_clip #(
		.CLIP_ROM_ENTRIES (CLIP_ROM_ENTRIES)
	) u_clip (
		.clk     (clk),
		.raw     (rd_data),
		.clipped (clip_out)
	);

	arbsc_posdiv u_posdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_READ),
		.played   (played_q),
		.rate     (rate_q),
		.base     (base_q),
		.done     (div_done),
		.position (div_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			played_q    <= '0;
			running_q   <= 1'b0;
			rate_q      <= arbsc_pkg::RATE_RESET;
			base_q      <= '0;
			pull_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (arbsc_pkg::cfg_idx_t'(cfg.index))
					arbsc_pkg::CFG_RUNNING:     running_q <= cfg.data[0];
					arbsc_pkg::CFG_SAMPLE_RATE: rate_q    <= cfg.data[arbsc_pkg::RATE_W-1:0];
					arbsc_pkg::CFG_POS_BASE:    base_q    <= cfg.data[arbsc_pkg::BASE_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				pull_ok_q <= mem_re;
				unique case (req_code)
					arbsc_pkg::REQ_ENQUEUE: begin
						if (mem_we) begin
							wr_ptr_q <= wr_next;
						end
					end
					arbsc_pkg::REQ_PULL: begin
						if (mem_re) begin
							rd_ptr_q <= rd_next;
							if (played_q != '1) begin
								played_q <= played_q + 1'b1;
							end
						end
					end
					arbsc_pkg::REQ_FLUSH: rd_ptr_q <= wr_ptr_q;
					arbsc_pkg::REQ_CLEAR: played_q <= '0;
					arbsc_pkg::REQ_RESET_ALL: begin
						rd_ptr_q <= '0;
						wr_ptr_q <= '0;
						played_q <= '0;
						base_q   <= '0;
					end
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_READ;
				S_READ: state_q <= S_DIV;
				S_DIV:  if (div_done) state_q <= S_OUT;
				S_OUT:  if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= req_status;
		end
		if (state_q == S_DIV) begin
			sample_q <= pull_ok_q ? clip_out : '0;
		end
		if (load_out) begin
			out_sample_q <= $signed(sample_q);
			out_status_q <= status_q;
			out_fill_q   <= fill_ext[arbsc_pkg::FILL_OUT_W-1:0];
			out_pos_q    <= div_pos;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.sample_out  = out_sample_q;
	assign rsp.status      = out_status_q;
	assign rsp.fill_level  = out_fill_q;
	assign rsp.position_ms = out_pos_q;

endmodule

[rtl/core/arbsc_ram.sv]
module arbsc_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic [arbsc_pkg::SAMPLE_W-1:0]    wdata,
	input  logic                              re,
	input  logic [AW-1:0]                     raddr,
	output logic [arbsc_pkg::SAMPLE_W-1:0]    rdata
);

	logic [arbsc_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
	logic [arbsc_pkg::SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/arbsc_clip.sv]
module arbsc_clip #(
	parameter int CLIP_ROM_ENTRIES = 1024
) (
	input  logic                           clk,
	input  logic [arbsc_pkg::SAMPLE_W-1:0] raw,
	output logic [arbsc_pkg::SAMPLE_W-1:0] clipped
);

	localparam int ROM_AW = $clog2(CLIP_ROM_ENTRIES);

	typedef logic [arbsc_pkg::SAMPLE_W-1:0] rom_t [CLIP_ROM_ENTRIES];

	// round(16384 * tanh(k/512)) computed as (e-1)/(e+1) with e = exp(k/256).
	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] e, a, b, step;
		step = arbsc_pkg::exp_step();
		e    = arbsc_pkg::ONE_Q38;
		for (int k = 0; k < CLIP_ROM_ENTRIES; k++) begin
			a = e;
			b = arbsc_pkg::ONE_Q38;
			for (int s = 0; s < 18; s++) begin
				if (a[63:46] != '0) begin
					a = a >> 1;
					b = b >> 1;
				end
			end
			rom[k] = 16'(arbsc_pkg::udiv64((a - b) * 64'd32768 + (a + b),
				64'd2 * (a + b)));
			e = e + arbsc_pkg::mul_high(e, step);
		end
		return rom;
	endfunction

	localparam rom_t CLIP_ROM = build_rom();

	logic                           neg;
	logic [16:0]                    mag;
	logic [16:0]                    over;
	logic [11:0]                    idx_full;
	logic [ROM_AW-1:0]              idx;
	logic [16:0]                    new_mag;
	logic [arbsc_pkg::SAMPLE_W-1:0] rom_q;
	logic [arbsc_pkg::SAMPLE_W-1:0] raw_q;
	logic                           neg_q;
	logic                           pass_q;

	always_comb begin
		neg      = raw[arbsc_pkg::SAMPLE_W-1];
		mag      = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
		over     = mag - arbsc_pkg::KNEE;
		idx_full = 12'(over >> arbsc_pkg::CLIP_SHIFT);
		if (32'(idx_full) >= CLIP_ROM_ENTRIES) begin
			idx = ROM_AW'(CLIP_ROM_ENTRIES - 1);
		end else begin
			idx = ROM_AW'(idx_full);
		end
	end

	// The table is read through a register, so the clipped sample follows raw in the next cycle.
	always_ff @(posedge clk) begin
		rom_q  <= CLIP_ROM[idx];
		raw_q  <= raw;
		neg_q  <= neg;
		pass_q <= (mag <= arbsc_pkg::KNEE);
	end

	always_comb begin
		new_mag = arbsc_pkg::KNEE + 17'(rom_q);
		if (pass_q) begin
			clipped = raw_q;
		end else if (neg_q) begin
			clipped = 16'(17'h10000 - new_mag);
		end else begin
			clipped = new_mag[15:0];
		end
	end

endmodule

[rtl/core/arbsc_posdiv.sv]
module arbsc_posdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [arbsc_pkg::PLAYED_W-1:0]    played,
	input  logic [arbsc_pkg::RATE_W-1:0]      rate,
	input  logic [arbsc_pkg::BASE_W-1:0]      base,
	output logic                              done,
	output logic [arbsc_pkg::POS_W-1:0]       position
);

	localparam int NW    = arbsc_pkg::DIVIDEND_W;
	localparam int RW    = arbsc_pkg::RATE_W;
	localparam int CNT_W = $clog2(NW + 1);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_DIV  = 3'b010,
		D_SUM  = 3'b100
	} dstate_t;

	dstate_t                          state_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic                             done_q;
	logic [NW-1:0]                    dq_q;
	logic [RW-1:0]                    rem_q;
	logic [arbsc_pkg::POS_W-1:0]      pos_q;

	logic [NW-1:0]                    frames;
	logic [NW-1:0]                    dividend;
	logic [RW:0]                      rem_sh;
	logic                             ge;
	logic [RW:0]                      rem_sub;
	logic [NW:0]                      sum;

	always_comb begin
		frames   = NW'(played >> 1);
		// frames * 1000 = frames * 1024 - frames * 16 - frames * 8
		dividend = (frames << 10) - (frames << 4) - (frames << 3);
		rem_sh   = {rem_q, dq_q[NW-1]};
		ge       = rem_sh >= {1'b0, rate};
		rem_sub  = rem_sh - {1'b0, rate};
		sum      = (NW + 1)'(base) + (NW + 1)'(dq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						cnt_q   <= CNT_W'(NW);
						// A zero rate leaves the position at the base alone.
						state_q <= (rate == '0) ? D_SUM : D_DIV;
					end
				end
				D_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= D_SUM;
					end
				end
				D_SUM: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			dq_q  <= (rate == '0) ? '0 : dividend;
			rem_q <= '0;
		end else if (state_q == D_DIV) begin
			rem_q <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
			dq_q  <= {dq_q[NW-2:0], ge};
		end
		if (state_q == D_SUM) begin
			if (sum[NW:arbsc_pkg::POS_W] != '0) begin
				pos_q <= '1;
			end else begin
				pos_q <= sum[arbsc_pkg::POS_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign position = pos_q;

endmodule

[rtl/core/arbsc_chk.sv]
module arbsc_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic [arbsc_pkg::STATUS_W-1:0]     rsp_status,
	input logic [arbsc_pkg::SAMPLE_W-1:0]     rsp_sample_out,
	input logic [arbsc_pkg::POS_W-1:0]        rsp_position_ms
);

	// Requests are worked one at a time, so an accepted request drops ready.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in work");

	// Only a successful pull carries a sample.
	a_sample_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != arbsc_pkg::ST_OK) |-> (rsp_sample_out == '0))
		else $error("nonzero sample with a failing status");

	a_rsp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result withdrawn while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> ($stable(rsp_sample_out) && $stable(rsp_status)
			&& $stable(rsp_position_ms)))
		else $error("result changed while stalled");

endmodule

bind audio_ring_buffer_soft_clip_unit arbsc_chk u_arbsc_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_sample_out  (rsp.sample_out),
	.rsp_position_ms (rsp.position_ms)
);
